FILE: hdl/audio_loop_recorder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio loop recorder
// Shared property forms, clocked on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_LOOP_RECORDER_TOP_MACROS_SVH
`define AUDIO_LOOP_RECORDER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ALR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ALR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/alr_pkg.sv
// ----------------------------------------------------------------------------
// Audio loop recorder package
// Sizes, constants, sequencer states and the multiplier control type.
// ----------------------------------------------------------------------------
package alr_pkg;

    localparam int DEPTH    = 4194304;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SAMPLE_W = 24;
    localparam int KNOB_W   = 17;
    localparam int HOLD_W   = 16;
    localparam int FRAC_W   = 16;
    localparam int ACC_W    = SAMPLE_W + FRAC_W + 1;

    localparam logic [KNOB_W-1:0]   KNOB_ONE      = KNOB_W'(65536);
    localparam logic [HOLD_W-1:0]   HOLD_RESET    = HOLD_W'(1000);
    localparam logic [SAMPLE_W-1:0] SAMPLE_SIGN   = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [ACC_W-1:0]    ROUND_HALF    = ACC_W'(32768);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPD,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic accum;
    } t_mac_ctl;

endpackage

FILE: hdl/audio_loop_recorder_top.sv
// ----------------------------------------------------------------------------
// Audio loop recorder, top level
// A result item is registered in DONE, after READ, UPD, MUL1 and MUL2.
// No new item is taken before the last leaves DONE: one store read port,
// the overdub write and two passes through the shared multiplier for the mix.
// Reset is synchronous and active low; the store needs no clearing pass.
// ----------------------------------------------------------------------------
//
// Each input item carries one mono sample plus the button events that came
// before it. The sequencer walks one item through these steps:
//   IDLE  accept the item, apply record press, hold clear and play press
//   READ  present the play position to the store
//   UPD   read data arrives; overdub write, take count, automatic close,
//         position advance
//   MUL1  accumulator = stored * knob + one half
//   MUL2  accumulator += input * (1 - knob)
//   DONE  load the output register once it is free
// A new item is taken in IDLE even while the previous result still waits in
// the output register.
//
// The store is never swept. While the loop is open, every entry at or above
// the take count reads as zero; a hold clear just reopens the loop with a
// take count of zero, which makes the whole store read as zero at once. A
// new take writes positions upward from zero, so each entry is rewritten
// before it can be read as valid again.
//
`include "audio_loop_recorder_top_macros.svh"

module audio_loop_recorder_top
    import alr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration: hold threshold in milliseconds
    input  logic                       i_cfg_we,
    input  logic [HOLD_W-1:0]          i_cfg_wdata,
    // Input item
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_in_sample,
    input  logic [KNOB_W-1:0]          i_mix_knob,
    input  logic                       i_rec_press,
    input  logic [HOLD_W-1:0]          i_rec_held_ms,
    input  logic                       i_play_press,
    // Result item
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_out_sample,
    output logic                       o_playing,
    output logic                       o_recording,
    output logic                       o_loop_open
);

    // Sequencer and loop state.
    t_state              r_state,       n_state;
    logic [HOLD_W-1:0]   r_hold_thr;
    logic [ADDR_W-1:0]   r_play_pos,    n_play_pos;
    logic [CNT_W-1:0]    r_loop_length, n_loop_length;
    logic [CNT_W-1:0]    r_take_count,  n_take_count;
    logic                r_length_open, n_length_open;
    logic                r_rec_on,      n_rec_on;
    logic                r_play_on,     n_play_on;
    logic                r_clear_armed, n_clear_armed;

    // Item being worked on.
    logic [SAMPLE_W-1:0] r_x,    n_x;
    logic [KNOB_W-1:0]   r_knob, n_knob;
    logic [SAMPLE_W-1:0] r_s,    n_s;

    // Output register.
    logic                r_out_valid,  n_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample, n_out_sample;
    logic                r_playing,    n_playing;
    logic                r_recording,  n_recording;
    logic                r_loop_open,  n_loop_open;

    // Store and multiplier connections.
    logic                mem_we;
    logic [SAMPLE_W-1:0] mem_rdata;
    t_mac_ctl            mac_ctl;
    logic [SAMPLE_W-1:0] mac_a;
    logic [KNOB_W-1:0]   mac_b;
    logic [ACC_W-1:0]    mac_acc;

    // Datapath helpers for the update step.
    logic                rd_blank;
    logic [SAMPLE_W-1:0] stored;
    logic [SAMPLE_W:0]   dub_sum;
    logic [SAMPLE_W-1:0] dub_avg;
    logic [CNT_W-1:0]    pos_inc;
    logic [SAMPLE_W-1:0] mix_out;

    alr_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_play_pos),
        .i_wdata (dub_avg),
        .i_raddr (r_play_pos),
        .o_rdata (mem_rdata)
    );

    alr_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (mac_acc)
    );

    // Entries not yet written by the current take read as silence.
    assign rd_blank = r_length_open && (CNT_W'(r_play_pos) >= r_take_count);
    assign stored   = rd_blank ? '0 : mem_rdata;

    // Overdub is the floor of the average, an arithmetic shift of the sum.
    assign dub_sum  = {r_x[SAMPLE_W-1], r_x} + {stored[SAMPLE_W-1], stored};
    assign dub_avg  = dub_sum[SAMPLE_W:1];

    assign pos_inc  = CNT_W'(r_play_pos) + CNT_W'(1);

    // The accumulator holds the offset-binary mix scaled by 2^16; flipping
    // the sign bit returns it to two's complement.
    assign mix_out  = mac_acc[FRAC_W +: SAMPLE_W] ^ SAMPLE_SIGN;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_playing    = r_playing;
    assign o_recording  = r_recording;
    assign o_loop_open  = r_loop_open;

    always_comb begin
        n_state       = r_state;
        n_play_pos    = r_play_pos;
        n_loop_length = r_loop_length;
        n_take_count  = r_take_count;
        n_length_open = r_length_open;
        n_rec_on      = r_rec_on;
        n_play_on     = r_play_on;
        n_clear_armed = r_clear_armed;
        n_x           = r_x;
        n_knob        = r_knob;
        n_s           = r_s;
        n_out_valid   = r_out_valid;
        n_out_sample  = r_out_sample;
        n_playing     = r_playing;
        n_recording   = r_recording;
        n_loop_open   = r_loop_open;
        mem_we        = 1'b0;
        mac_ctl       = '0;
        mac_a         = r_s ^ SAMPLE_SIGN;
        mac_b         = r_knob;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_x    = i_in_sample;
                    n_knob = (i_mix_knob > KNOB_ONE) ? KNOB_ONE : i_mix_knob;

                    // Record press: close the first take if there is one.
                    if (i_rec_press) begin
                        if (n_length_open && n_rec_on && (n_take_count != '0)) begin
                            n_length_open = 1'b0;
                            n_loop_length = n_take_count;
                            n_take_count  = '0;
                            n_play_pos    = '0;
                        end
                        n_clear_armed = 1'b1;
                        n_play_on     = 1'b1;
                        n_rec_on      = !n_rec_on;
                    end

                    // Long hold after an arming press empties the loop.
                    if (n_clear_armed && (i_rec_held_ms >= r_hold_thr)) begin
                        n_play_pos    = '0;
                        n_loop_length = CNT_W'(DEPTH);
                        n_take_count  = '0;
                        n_length_open = 1'b1;
                        n_rec_on      = 1'b0;
                        n_play_on     = 1'b0;
                        n_clear_armed = 1'b0;
                    end

                    // Play press does nothing on an open loop that is idle.
                    if (i_play_press && !(!n_rec_on && n_length_open)) begin
                        n_play_on = !n_play_on;
                        n_rec_on  = 1'b0;
                    end

                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (r_rec_on) begin
                    mem_we = 1'b1;
                    n_s    = dub_avg;
                    if (r_length_open) begin
                        n_take_count = r_take_count + CNT_W'(1);
                    end
                end else begin
                    n_s = stored;
                end

                // A take that fills the whole store closes itself.
                if (n_take_count >= CNT_W'(DEPTH)) begin
                    n_length_open = 1'b0;
                    n_loop_length = CNT_W'(DEPTH);
                    n_take_count  = '0;
                end

                if (r_play_on) begin
                    n_play_pos = (pos_inc >= n_loop_length) ? '0 : ADDR_W'(pos_inc);
                end

                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                mac_ctl.start = 1'b1;
                mac_a         = r_s ^ SAMPLE_SIGN;
                mac_b         = r_knob;
                n_state       = ST_MUL2;
            end
            ST_MUL2: begin
                mac_ctl.accum = 1'b1;
                mac_a         = r_x ^ SAMPLE_SIGN;
                mac_b         = KNOB_ONE - r_knob;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_rec_on ? r_s : mix_out;
                    n_playing    = r_play_on;
                    n_recording  = r_rec_on;
                    n_loop_open  = r_length_open;
                    n_state      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_hold_thr    <= HOLD_RESET;
            r_play_pos    <= '0;
            r_loop_length <= CNT_W'(DEPTH);
            r_take_count  <= '0;
            r_length_open <= 1'b1;
            r_rec_on      <= 1'b0;
            r_play_on     <= 1'b0;
            r_clear_armed <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            if (i_cfg_we) begin
                r_hold_thr <= i_cfg_wdata;
            end
            r_play_pos    <= n_play_pos;
            r_loop_length <= n_loop_length;
            r_take_count  <= n_take_count;
            r_length_open <= n_length_open;
            r_rec_on      <= n_rec_on;
            r_play_on     <= n_play_on;
            r_clear_armed <= n_clear_armed;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_knob       <= n_knob;
        r_s          <= n_s;
        r_out_sample <= n_out_sample;
        r_playing    <= n_playing;
        r_recording  <= n_recording;
        r_loop_open  <= n_loop_open;
    end

    // Recording always runs with playback on.
    `ALR_ASSERT_SAME(a_rec_needs_play, r_rec_on, r_play_on, "recording without playback")
    // An open loop keeps the full store length.
    `ALR_ASSERT_SAME(a_open_full_len, r_length_open, r_loop_length == CNT_W'(DEPTH),
                     "open loop with a fixed length")
    // The play position stays inside the loop.
    `ALR_ASSERT_SAME(a_pos_in_loop, 1'b1, CNT_W'(r_play_pos) < r_loop_length,
                     "play position outside the loop")
    // An accepted item always moves on to the store read.
    `ALR_ASSERT_NEXT(a_accept_reads, i_in_valid && o_in_ready, r_state == ST_READ,
                     "accepted item did not start a read")

endmodule

FILE: hdl/alr_mem.sv
// ----------------------------------------------------------------------------
// Loop sample store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module alr_mem
    import alr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  logic [SAMPLE_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]   i_raddr,
    output logic [SAMPLE_W-1:0] o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/alr_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Multiplies an offset-binary sample by a Q1.16 weight and accumulates.
// ----------------------------------------------------------------------------
module alr_mac
    import alr_pkg::*;
(
    input  logic                i_clk,
    input  t_mac_ctl            i_ctl,
    input  logic [SAMPLE_W-1:0] i_a,
    input  logic [KNOB_W-1:0]   i_b,
    output logic [ACC_W-1:0]    o_acc
);

    logic [ACC_W-1:0] prod;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;

    assign prod = ACC_W'(i_a) * ACC_W'(i_b);

    // A start seeds the rounding constant so the result only needs a shift.
    always_comb begin
        n_acc = r_acc;
        if (i_ctl.start) begin
            n_acc = ROUND_HALF + prod;
        end else if (i_ctl.accum) begin
            n_acc = r_acc + prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule
